[hw/rtl/ising_energy_enumerator_top_macros.svh]
// Assertion macros for the top-level RTL file.
`ifndef ISING_ENERGY_ENUMERATOR_TOP_MACROS_SVH
`define ISING_ENERGY_ENUMERATOR_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define IEE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define IEE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IEE_ASSERT(label, prop, msg)
`define IEE_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

[hw/rtl/iee_pkg.sv]
`timescale 1ns / 1ps
package iee_pkg;

  localparam int SPIN_IDX_W = 5;
  localparam int COUP_W     = 16;
  localparam int MASK_W     = 18;
  localparam int ENERGY_W   = 32;
  localparam int ACC_W      = 40;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic signed [ACC_W-1:0] ACC_EMAX = ACC_W'({1'b0, {(ENERGY_W-1){1'b1}}});
  localparam logic signed [ACC_W-1:0] ACC_EMIN = -ACC_EMAX - ACC_W'(1);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LD_RD,
    ST_LD_WR,
    ST_EV_TOP,
    ST_EV_BASE,
    ST_EV_RUN,
    ST_EV_DRAIN,
    ST_EV_FIN
  } iee_state_t;

endpackage

[hw/rtl/iee_ram.sv]
`timescale 1ns / 1ps
module iee_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/ising_energy_enumerator_top.sv]
`timescale 1ns / 1ps
// Load: accept, coupling read, write back; a load with an index out of range or a
// row not below its column ends at accept; no result.
// Evaluate: top, base, one coupling-store read per spin, drain, finish (mask zero
// skips to finish), which raises result_valid once the output is free.
// Reset: synchronous; clears the running sum and output valid, then sweeps all
// SPINS*SPINS coupling-store entries (324 at SPINS=18) to zero with stall high.
`include "ising_energy_enumerator_top_macros.svh"
module ising_energy_enumerator_top import iee_pkg::*; #(
  parameter int SPINS = 18
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic                       opcode,
  input  logic [SPIN_IDX_W-1:0]      row_spin,
  input  logic [SPIN_IDX_W-1:0]      col_spin,
  input  logic signed [COUP_W-1:0]   coupling,
  input  logic [MASK_W-1:0]          config_mask,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic signed [ENERGY_W-1:0] energy,
  output logic [MASK_W-1:0]          mask_echo
);

  localparam int IW        = (SPINS > 1) ? $clog2(SPINS) : 1;
  localparam int CDEPTH    = SPINS * SPINS;
  localparam int CW        = $clog2(CDEPTH);
  localparam int MASK_BITS = (SPINS < MASK_W) ? SPINS : MASK_W;
  localparam int AW        = MASK_BITS;
  localparam int EDEPTH    = 1 << AW;
  localparam logic [MASK_W-1:0] SPIN_MASK = MASK_W'((64'd1 << MASK_BITS) - 64'd1);
  localparam logic [IW-1:0]     LAST_SPIN = IW'(SPINS - 1);
  localparam logic [CW-1:0]     LAST_ADDR = CW'(CDEPTH - 1);
  localparam logic [CW-1:0]     SPINS_C   = CW'(SPINS);

  iee_state_t state, state_next;

  logic                       item_acc;
  logic                       ld_ok;
  logic                       out_free;
  logic [MASK_W-1:0]          mask_r;
  logic [MASK_W-1:0]          prev_r;
  logic                       prev_zero;
  logic [IW-1:0]              top_r;
  logic [IW-1:0]              top_next;
  logic [MASK_W-1:0]          prev_next;
  logic [IW-1:0]              ld_row;
  logic [IW-1:0]              ld_col;
  logic signed [COUP_W-1:0]   ld_val;
  logic [IW-1:0]              i_cnt;
  logic                       pend_use;
  logic                       pend_neg;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    acc_base;
  logic signed [ACC_W-1:0]    cst_j;
  logic signed [ACC_W-1:0]    term;
  logic signed [ENERGY_W-1:0] total;
  logic signed [ENERGY_W-1:0] sat;
  logic [CW-1:0]              clr_cnt;
  logic [SPINS-1:0]           spins_v;
  logic [IW-1:0]              ev_row;
  logic [IW-1:0]              ev_col;
  logic [CW-1:0]              ev_addr;
  logic [CW-1:0]              ld_addr;

  logic                       cst_we;
  logic [CW-1:0]              cst_waddr;
  logic [COUP_W-1:0]          cst_wdata;
  logic [CW-1:0]              cst_raddr;
  logic [COUP_W-1:0]          cst_rdata;
  logic                       et_we;
  logic [AW-1:0]              et_raddr;
  logic [ENERGY_W-1:0]        et_rdata;

  iee_ram #(.WIDTH(COUP_W), .DEPTH(CDEPTH)) u_coup_ram (
    .clk   (clk),
    .we    (cst_we),
    .waddr (cst_waddr),
    .wdata (cst_wdata),
    .raddr (cst_raddr),
    .rdata (cst_rdata)
  );

  iee_ram #(.WIDTH(ENERGY_W), .DEPTH(EDEPTH)) u_energy_ram (
    .clk   (clk),
    .we    (et_we),
    .waddr (mask_r[AW-1:0]),
    .wdata (sat),
    .raddr (et_raddr),
    .rdata (et_rdata)
  );

  assign item_acc = item_valid && !item_stall;
  assign ld_ok    = (int'(col_spin) < SPINS) && (row_spin < col_spin);
  assign out_free = !result_valid || !result_stall;
  assign spins_v  = SPINS'(mask_r);

  always_comb begin
    top_next = '0;
    for (int k = 0; k < SPINS; k++) begin
      if (spins_v[k]) begin
        top_next = IW'(k);
      end
    end
  end

  assign prev_next = mask_r & ~(MASK_W'(1) << top_next);

  assign ev_row  = (i_cnt < top_r) ? i_cnt : top_r;
  assign ev_col  = (i_cnt < top_r) ? top_r : i_cnt;
  assign ev_addr = CW'(ev_row) * SPINS_C + CW'(ev_col);
  assign ld_addr = CW'(ld_row) * SPINS_C + CW'(ld_col);

  assign acc_base = prev_zero ? ACC_W'(total) : ACC_W'(signed'(et_rdata));
  assign cst_j    = ACC_W'(signed'(cst_rdata));
  assign term     = pend_use ? (pend_neg ? -(cst_j <<< 1) : (cst_j <<< 1)) : '0;

  always_comb begin
    if (acc > ACC_EMAX) begin
      sat = ENERGY_W'(ACC_EMAX);
    end else if (acc < ACC_EMIN) begin
      sat = ENERGY_W'(ACC_EMIN);
    end else begin
      sat = ENERGY_W'(acc);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == LAST_ADDR) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item_acc) begin
          if (opcode == OP_EVAL) begin
            state_next = ST_EV_TOP;
          end else if (ld_ok) begin
            state_next = ST_LD_RD;
          end
        end
      end
      ST_LD_RD:    state_next = ST_LD_WR;
      ST_LD_WR:    state_next = ST_IDLE;
      ST_EV_TOP:   state_next = (mask_r == '0) ? ST_EV_FIN : ST_EV_BASE;
      ST_EV_BASE:  state_next = ST_EV_RUN;
      ST_EV_RUN: begin
        if (i_cnt == LAST_SPIN) begin
          state_next = ST_EV_DRAIN;
        end
      end
      ST_EV_DRAIN: state_next = ST_EV_FIN;
      ST_EV_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_stall = 1'b1;
    cst_we     = 1'b0;
    cst_waddr  = ld_addr;
    cst_wdata  = ld_val;
    cst_raddr  = ld_addr;
    et_we      = 1'b0;
    et_raddr   = prev_r[AW-1:0];
    case (state)
      ST_CLEAR: begin
        cst_we    = 1'b1;
        cst_waddr = clr_cnt;
        cst_wdata = '0;
      end
      ST_IDLE:   item_stall = 1'b0;
      ST_LD_WR:  cst_we = 1'b1;
      ST_EV_RUN: cst_raddr = ev_addr;
      ST_EV_FIN: et_we = out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_cnt      <= '0;
      total        <= '0;
      result_valid <= 1'b0;
      pend_use     <= 1'b0;
    end else begin
      state    <= state_next;
      pend_use <= (state == ST_EV_RUN) && (i_cnt != top_r);
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + CW'(1);
      end
      if (state == ST_LD_WR) begin
        total <= total - ENERGY_W'(signed'(cst_rdata)) + ENERGY_W'(ld_val);
      end
      if (et_we) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_acc) begin
      ld_row <= IW'(row_spin);
      ld_col <= IW'(col_spin);
      ld_val <= coupling;
      mask_r <= config_mask & SPIN_MASK;
    end
    pend_neg <= !spins_v[i_cnt];
    case (state)
      ST_EV_TOP: begin
        top_r     <= top_next;
        prev_r    <= prev_next;
        prev_zero <= (prev_next == '0);
        acc       <= ACC_W'(total);
      end
      ST_EV_BASE: i_cnt <= '0;
      ST_EV_RUN: begin
        acc   <= ((i_cnt == '0) ? acc_base : acc) + term;
        i_cnt <= i_cnt + IW'(1);
      end
      ST_EV_DRAIN: acc <= acc + term;
      default: begin
      end
    endcase
    if (et_we) begin
      energy    <= sat;
      mask_echo <= mask_r;
    end
  end

  `IEE_ASSERT_ALWAYS(a_reset_clears_out, rst |=> !result_valid, "output valid after reset")
  `IEE_ASSERT(a_eval_starts, (item_acc && opcode == OP_EVAL) |=> (state == ST_EV_TOP), "eval not started")
  `IEE_ASSERT(a_store_shows, et_we |=> result_valid, "stored energy not presented")
  `IEE_ASSERT(a_result_from_fin, $rose(result_valid) |-> $past(state == ST_EV_FIN), "result outside finish")
  `IEE_ASSERT(a_run_bound, (state == ST_EV_RUN) |-> (i_cnt <= LAST_SPIN), "spin counter overran")

endmodule
